// File: design/fraction_add_reduce_defines.svh
// assertion macros for the fraction adder checker
`ifndef FRACTION_ADD_REDUCE_DEFINES_SVH
`define FRACTION_ADD_REDUCE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction_add_reduce assertion failed");

// antecedent implies consequent in the following cycle
`define FRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction_add_reduce assertion failed");

`endif

// File: design/fra_pkg.sv
// shared types and constants for the fraction adder
package fra_pkg;

  localparam int FIELD_W          = 16;
  localparam int NUM_W            = 33;
  localparam int DEN_W            = 32;
  localparam int NUMBER_WIDTH_DEF = 16;
  localparam int DIV_STEPS        = NUM_W;
  localparam int CNT_W            = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {DIV_B, DIV_D, DIV_S, DIV_L} div_sel_t;
  typedef enum logic [1:0] {MUL_L, MUL_A, MUL_C} mul_sel_t;
  typedef enum logic [1:0] {OUT_ERR, OUT_ZERO, OUT_RED} out_sel_t;
  typedef enum logic {GCD_BD, GCD_SL} gcd_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_GCD1, ST_DIVB_GO, ST_DIVB, ST_DIVD, ST_MULA, ST_MULC,
    ST_ADD, ST_ZCHK, ST_GCD2, ST_DIVS_GO, ST_DIVS, ST_DIVL,
    ST_OUT_ERR, ST_OUT_ZERO, ST_OUT_RED
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     gcd_start;
    gcd_sel_t gcd_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_q;
    div_sel_t save_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     save_lcm;
    logic     save_sum;
    logic     add_sum;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_done;
    logic sum_zero;
  } status_t;

endpackage

// File: design/fra_ifs.sv
// valid/ready channel interfaces for operands and results
interface fra_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_numerator;
  logic [15:0] first_denominator;
  logic [15:0] second_numerator;
  logic [15:0] second_denominator;
  modport source (output valid, first_numerator, first_denominator, second_numerator,
                  second_denominator, input ready);
  modport sink (input valid, first_numerator, first_denominator, second_numerator,
                second_denominator, output ready);
endinterface

interface fra_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] sum_numerator;
  logic [31:0] sum_denominator;
  logic        divide_error;
  modport source (output valid, sum_numerator, sum_denominator, divide_error, input ready);
  modport sink (input valid, sum_numerator, sum_denominator, divide_error, output ready);
endinterface

// File: design/fraction_add_reduce.sv
// top level: sum of two fractions reduced to lowest terms
//
//  channel  | direction | carries
//  in_ch    | sink      | first/second numerator and denominator, 16 bits each
//  out_ch   | source    | sum_numerator (33), sum_denominator (32), divide_error
//
// one transaction at a time; after acceptance a zero denominator goes straight to the error
// result, a zero sum runs the first gcd and two divisions, a full reduction both gcds and
// all four divisions; each gcd step is one shift or subtract; divisions share the divider.
// reset is synchronous, active low, and clears the controller and output valid.
// a finished result waits in the output register while the next transaction is taken;
// the block stalls only when a second result is ready before the first is taken.
module fraction_add_reduce import fra_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input logic   clk,
  input logic   rst_n,
  fra_in_if.sink    in_ch,
  fra_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  fra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fra_dp #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .a_in    (in_ch.first_numerator),
    .b_in    (in_ch.first_denominator),
    .c_in    (in_ch.second_numerator),
    .d_in    (in_ch.second_denominator),
    .num_out (out_ch.sum_numerator),
    .den_out (out_ch.sum_denominator),
    .err_out (out_ch.divide_error)
  );

endmodule

// File: design/fra_div.sv
// restoring divider, one quotient bit per cycle
module fra_div import fra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      q_nxt   = {q_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: design/fra_dp.sv
// datapath: operand registers, binary gcd, shared multiplier and divider, result register
module fra_dp import fra_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [FIELD_W-1:0] a_in,
  input  logic [FIELD_W-1:0] b_in,
  input  logic [FIELD_W-1:0] c_in,
  input  logic [FIELD_W-1:0] d_in,
  output logic [NUM_W-1:0]   num_out,
  output logic [DEN_W-1:0]   den_out,
  output logic               err_out
);

  localparam int OPW = (NUMBER_WIDTH < FIELD_W) ? NUMBER_WIDTH : FIELD_W;
  localparam logic [FIELD_W-1:0] OP_MASK = {FIELD_W{1'b1}} >> (FIELD_W - OPW);
  localparam int KW = $clog2(NUM_W + 1);

  logic [FIELD_W-1:0] a_r, b_r, c_r, d_r, bq_r, dq_r;
  logic [DEN_W-1:0]   g_r, lcm_r, den_r, prod_r;
  logic [NUM_W-1:0]   sum_r, num_r;
  logic [NUM_W-1:0]   gx_r, gy_r;
  logic [KW-1:0]      gk_r;
  logic               gbusy_r;
  logic               gdone;
  logic [NUM_W-1:0]   gshift;
  logic [NUM_W-1:0]   div_dividend;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [FIELD_W-1:0] mop1, mop2;
  logic [NUM_W-1:0]   num_out_r;
  logic [DEN_W-1:0]   den_out_r;
  logic               err_out_r;

  assign gdone  = gbusy_r && (gx_r == '0);
  assign gshift = gy_r << gk_r;

  // binary gcd, one subtract or shift per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0;
    end else if (cmd.gcd_start) begin
      gbusy_r <= 1'b1;
    end else if (gdone) begin
      gbusy_r <= 1'b0;
    end
    if (cmd.gcd_start) begin
      gk_r <= '0;
      if (cmd.gcd_sel == GCD_BD) begin
        gx_r <= NUM_W'(b_r);
        gy_r <= NUM_W'(d_r);
      end else begin
        gx_r <= sum_r;
        gy_r <= {1'b0, lcm_r};
      end
    end else if (gbusy_r && !gdone) begin
      if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
    if (gdone) begin
      g_r <= gshift[DEN_W-1:0];
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_B:   div_dividend = NUM_W'(b_r);
      DIV_D:   div_dividend = NUM_W'(d_r);
      DIV_S:   div_dividend = sum_r;
      DIV_L:   div_dividend = NUM_W'(lcm_r);
      default: div_dividend = '0;
    endcase
  end

  fra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    case (cmd.mul_sel)
      MUL_L:   begin mop1 = bq_r; mop2 = d_r; end
      MUL_A:   begin mop1 = a_r;  mop2 = dq_r; end
      MUL_C:   begin mop1 = c_r;  mop2 = bq_r; end
      default: begin mop1 = '0;   mop2 = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r <= a_in & OP_MASK;
      b_r <= b_in & OP_MASK;
      c_r <= c_in & OP_MASK;
      d_r <= d_in & OP_MASK;
    end
    if (cmd.save_q) begin
      case (cmd.save_sel)
        DIV_B:   bq_r  <= div_quot[FIELD_W-1:0];
        DIV_D:   dq_r  <= div_quot[FIELD_W-1:0];
        DIV_S:   num_r <= div_quot;
        DIV_L:   den_r <= div_quot[DEN_W-1:0];
        default: ;
      endcase
    end
    if (cmd.mul_en) begin
      prod_r <= mop1 * mop2;
    end
    if (cmd.save_lcm) begin
      lcm_r <= prod_r;
    end
    if (cmd.save_sum) begin
      sum_r <= NUM_W'(prod_r);
    end else if (cmd.add_sum) begin
      sum_r <= sum_r + NUM_W'(prod_r);
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_ERR: begin
          num_out_r <= '0;
          den_out_r <= '0;
          err_out_r <= 1'b1;
        end
        OUT_ZERO: begin
          num_out_r <= '0;
          den_out_r <= lcm_r;
          err_out_r <= 1'b0;
        end
        default: begin
          num_out_r <= num_r;
          den_out_r <= den_r;
          err_out_r <= 1'b0;
        end
      endcase
    end
  end

  assign status.den_zero = (b_r == '0) || (d_r == '0);
  assign status.gcd_done = gdone;
  assign status.div_done = div_done;
  assign status.sum_zero = (sum_r == '0);

  assign num_out = num_out_r;
  assign den_out = den_out_r;
  assign err_out = err_out_r;

endmodule

// File: design/fra_ctrl.sv
// controller: sequences gcd, divisions and multiplies for one transaction
module fra_ctrl import fra_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.den_zero) begin
          state_nxt = ST_OUT_ERR;
        end else begin
          cmd.gcd_start = 1'b1;
          cmd.gcd_sel   = GCD_BD;
          state_nxt     = ST_GCD1;
        end
      end
      ST_GCD1: begin
        if (status.gcd_done) begin
          state_nxt = ST_DIVB_GO;
        end
      end
      ST_DIVB_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_B;
        state_nxt     = ST_DIVB;
      end
      ST_DIVB: begin
        if (status.div_done) begin
          cmd.save_q    = 1'b1;
          cmd.save_sel  = DIV_B;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_D;
          state_nxt     = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (status.div_done) begin
          cmd.save_q   = 1'b1;
          cmd.save_sel = DIV_D;
          cmd.mul_en   = 1'b1;
          cmd.mul_sel  = MUL_L;
          state_nxt    = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd.save_lcm = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_A;
        state_nxt    = ST_MULC;
      end
      ST_MULC: begin
        cmd.save_sum = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_C;
        state_nxt    = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_sum = 1'b1;
        state_nxt   = ST_ZCHK;
      end
      ST_ZCHK: begin
        if (status.sum_zero) begin
          state_nxt = ST_OUT_ZERO;
        end else begin
          cmd.gcd_start = 1'b1;
          cmd.gcd_sel   = GCD_SL;
          state_nxt     = ST_GCD2;
        end
      end
      ST_GCD2: begin
        if (status.gcd_done) begin
          state_nxt = ST_DIVS_GO;
        end
      end
      ST_DIVS_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_S;
        state_nxt     = ST_DIVS;
      end
      ST_DIVS: begin
        if (status.div_done) begin
          cmd.save_q    = 1'b1;
          cmd.save_sel  = DIV_S;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_L;
          state_nxt     = ST_DIVL;
        end
      end
      ST_DIVL: begin
        if (status.div_done) begin
          cmd.save_q   = 1'b1;
          cmd.save_sel = DIV_L;
          state_nxt    = ST_OUT_RED;
        end
      end
      ST_OUT_ERR, ST_OUT_ZERO, ST_OUT_RED: begin
        if (state_r == ST_OUT_ERR) begin
          cmd.out_sel = OUT_ERR;
        end else if (state_r == ST_OUT_ZERO) begin
          cmd.out_sel = OUT_ZERO;
        end else begin
          cmd.out_sel = OUT_RED;
        end
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/fra_chk.sv
// port-level checker for the fraction adder, bound to the top level
`include "fraction_add_reduce_defines.svh"

module fra_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] sum_numerator,
  input logic [31:0] sum_denominator,
  input logic        divide_error
);

  // result held until taken
  `FRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // errors carry zero payload
  `FRA_ASSERT_IMP(a_err_zero, out_valid && divide_error,
                  sum_numerator == 33'd0 && sum_denominator == 32'd0)
  // a good sum always has a nonzero denominator
  `FRA_ASSERT_IMP(a_den_nz, out_valid && !divide_error, sum_denominator != 32'd0)
  // one transaction in flight
  `FRA_ASSERT_NEXT(a_one_flight, in_valid && in_ready, !in_ready)

endmodule

bind fraction_add_reduce fra_chk u_fra_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .sum_numerator   (out_ch.sum_numerator),
  .sum_denominator (out_ch.sum_denominator),
  .divide_error    (out_ch.divide_error)
);
